// ----- design/rs_pkg.sv -----
// ----------------------------------------------------------------------------
// rs_pkg: shared types and constants of the reservoir sampler
// Item kinds, the command passed from front to back, the result layout and
// the state codes of the back-end sequencer.
// ----------------------------------------------------------------------------
package rs_pkg;

    localparam int KIND_W      = 2;
    localparam int RECORD_W    = 64;
    localparam int WORD_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int SIZE_W      = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

    typedef logic [RECORD_W-1:0] t_record;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [SIZE_W-1:0]   t_size;

    typedef enum logic [KIND_W-1:0] {
        KIND_OFFER = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind   op;
        t_record record;
        t_word   rnd_word;
    } t_cmd;

    typedef struct packed {
        t_slot   slot;
        t_record value;
        t_word   seen;
        logic    empty;
        logic    last;
    } t_res;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_RD_WAIT,
        BK_RD_EMIT,
        BK_EMPTY
    } t_back_state;

endpackage

// ----- design/rs_in_if.sv -----
// ----------------------------------------------------------------------------
// rs_in_if: input item channel
// Valid/ready channel carrying one command item of the reservoir sampler.
// ----------------------------------------------------------------------------
interface rs_in_if;
    logic            valid;
    logic            ready;
    logic [1:0]      kind;
    rs_pkg::t_record record_value;
    rs_pkg::t_word   random_word;

    modport source (output valid, kind, record_value, random_word, input ready);
    modport sink   (input valid, kind, record_value, random_word, output ready);
endinterface

// ----- design/rs_out_if.sv -----
// ----------------------------------------------------------------------------
// rs_out_if: result item channel
// Valid/ready channel carrying one readout result of the reservoir sampler.
// ----------------------------------------------------------------------------
interface rs_out_if;
    logic            valid;
    logic            ready;
    rs_pkg::t_slot   slot_index;
    rs_pkg::t_record sample_value;
    rs_pkg::t_word   seen_total;
    logic            empty_res;
    logic            last;

    modport source (output valid, slot_index, sample_value, seen_total, empty_res, last,
                    input ready);
    modport sink   (input valid, slot_index, sample_value, seen_total, empty_res, last,
                    output ready);
endinterface

// ----- design/rs_front.sv -----
// ----------------------------------------------------------------------------
// rs_front: item intake and command queue
// Accepts input items, drops unknown kinds and queues the rest for the back.
// ----------------------------------------------------------------------------
module rs_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rs_in_if.sink        i_in,
    output rs_pkg::t_cmd o_cmd,
    output logic         o_cmd_valid,
    input  logic         i_cmd_pop
);
    import rs_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              full;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;

    assign full        = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign i_in.ready  = !full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.op       = t_kind'(i_in.kind);
        cmd_in.record   = i_in.record_value;
        cmd_in.rnd_word = i_in.random_word;
        // drop items of unknown kind at the door
        push = i_in.valid && !full &&
               (t_kind'(i_in.kind) inside {KIND_OFFER, KIND_READ, KIND_CLEAR});
    end

    always_comb begin
        n_wr_ptr = push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ----- design/rs_mod.sv -----
// ----------------------------------------------------------------------------
// rs_mod: serial remainder unit
// Restoring division, one dividend bit per cycle, returns dividend mod divisor.
// ----------------------------------------------------------------------------
module rs_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rs_pkg::t_word       i_dividend,
    input  logic [rs_pkg::WORD_W:0] i_divisor,
    output logic                o_done,
    output rs_pkg::t_word       o_rem
);
    import rs_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    t_word             r_rem, n_rem;
    t_word             r_dvd;
    logic [WORD_W:0]   r_dsr;
    logic [WORD_W:0]   shifted;

    // remainder stays below the divisor, so it always fits one word
    always_comb begin
        shifted = {r_rem, r_dvd[WORD_W-1]};
        if (shifted >= r_dsr) begin
            n_rem = WORD_W'(shifted - r_dsr);
        end else begin
            n_rem = shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == STEP_W'(WORD_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= STEP_W'(r_cnt + 1'b1);
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- design/rs_back.sv -----
// ----------------------------------------------------------------------------
// rs_back: reservoir execution
// Holds the seen counter, the sample store and the output register; runs
// offers, readouts and clears taken from the command queue.
// ----------------------------------------------------------------------------
module rs_back #(
    parameter int CAPACITY     = 64,
    parameter int RECORD_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  rs_pkg::t_size i_cfg_data,
    input  rs_pkg::t_cmd  i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    rs_out_if.source      o_out
);
    import rs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAPACITY);

    t_back_state           r_state, n_state;
    t_size                 r_size;
    t_word                 r_seen, n_seen;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_last_idx, n_last_idx;
    logic [RECORD_WIDTH-1:0] r_rec, n_rec;
    logic [RECORD_WIDTH-1:0] r_mem [CAPACITY];
    logic [RECORD_WIDTH-1:0] r_rd_q;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [RECORD_WIDTH-1:0] mem_wdata;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out, n_out;
    logic                  out_free;
    logic                  out_load;
    t_size                 eff;
    t_size                 held;
    t_size                 held_m1;
    t_word                 seen_inc;
    logic                  div_start;
    logic                  div_done;
    t_word                 div_rem;

    assign out_free = !r_out_valid || o_out.ready;
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + 32'd1;

    // slots in use after clamping the register to 1..CAPACITY
    always_comb begin
        if (r_size == '0) begin
            eff = SIZE_W'(1);
        end else if (r_size > CAP_SIZE) begin
            eff = CAP_SIZE;
        end else begin
            eff = r_size;
        end
        held    = (r_seen < WORD_W'(eff)) ? r_seen[SIZE_W-1:0] : eff;
        held_m1 = SIZE_W'(held - 1'b1);
    end

    rs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.rnd_word),
        .i_divisor  ({1'b0, r_seen} + 33'd1),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        KIND_OFFER: begin
                            if (r_seen >= WORD_W'(eff)) begin
                                n_state = BK_DIV;
                            end
                        end
                        KIND_READ: begin
                            n_state = (r_seen == '0) ? BK_EMPTY : BK_RD_WAIT;
                        end
                        default: n_state = BK_IDLE;
                    endcase
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_IDLE;
                end
            end
            BK_RD_WAIT: n_state = BK_RD_EMIT;
            BK_RD_EMIT: begin
                if (out_free) begin
                    n_state = (r_ptr == r_last_idx) ? BK_IDLE : BK_RD_WAIT;
                end
            end
            BK_EMPTY: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_cmd_pop  = 1'b0;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_seen[AW-1:0];
        mem_wdata  = i_cmd.record[RECORD_WIDTH-1:0];
        n_seen     = r_seen;
        n_ptr      = r_ptr;
        n_last_idx = r_last_idx;
        n_rec      = r_rec;
        out_load   = 1'b0;
        n_out      = r_out;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_rec     = i_cmd.record[RECORD_WIDTH-1:0];
                    case (i_cmd.op)
                        KIND_OFFER: begin
                            if (r_seen < WORD_W'(eff)) begin
                                mem_we = 1'b1;
                                n_seen = seen_inc;
                            end else begin
                                div_start = 1'b1;
                            end
                        end
                        KIND_READ: begin
                            n_ptr      = '0;
                            n_last_idx = held_m1[AW-1:0];
                        end
                        KIND_CLEAR: n_seen = '0;
                        default: n_seen = r_seen;
                    endcase
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    mem_waddr = div_rem[AW-1:0];
                    mem_wdata = r_rec;
                    mem_we    = (div_rem < WORD_W'(eff));
                    n_seen    = seen_inc;
                end
            end
            BK_RD_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out.slot  = t_slot'(r_ptr);
                    n_out.value = t_record'(r_rd_q);
                    n_out.seen  = r_seen;
                    n_out.empty = 1'b0;
                    n_out.last  = (r_ptr == r_last_idx);
                    n_ptr       = AW'(r_ptr + 1'b1);
                end
            end
            BK_EMPTY: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out.slot  = '0;
                    n_out.value = '0;
                    n_out.seen  = r_seen;
                    n_out.empty = 1'b1;
                    n_out.last  = 1'b1;
                end
            end
            default: out_load = 1'b0;
        endcase
        n_out_valid = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_size      <= SIZE_RESET;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_last_idx <= n_last_idx;
        r_rec      <= n_rec;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_q <= r_mem[r_ptr];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.slot_index   = r_out.slot;
    assign o_out.sample_value = r_out.value;
    assign o_out.seen_total   = r_out.seen;
    assign o_out.empty_res    = r_out.empty;
    assign o_out.last         = r_out.last;

endmodule

// ----- design/reservoir_sampler.sv -----
// ----------------------------------------------------------------------------
// reservoir_sampler: uniform stream sampler (Algorithm R)
// Keeps a random sample of up to sample_size records and lists it on demand.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: kind 0 offers record_value, kind 1 reads out the
//   reservoir, kind 2 clears it; kind 3 is accepted and dropped. An offer
//   with a full reservoir draws random_word mod (seen + 1) for the slot.
//   o_out returns readout results in slot order, last set on the final one;
//   an empty reservoir yields one result with empty_res set.
//   i_cfg_we / i_cfg_data write sample_size (0 acts as 1, values above
//   CAPACITY act as CAPACITY); write only while the block is idle.
// Timing:
//   A two-entry queue takes items while the back end works. An offer into a
//   filling reservoir, or a clear, is done as the item leaves the queue; an
//   offer into a full reservoir waits on the one-bit-per-cycle remainder unit.
//   A readout reads each result from the store, then loads it into the output
//   register before the next slot is read.
// Reset and stall:
//   Reset empties the queue and output, zeroes the seen count and sets
//   sample_size to 16. A stalled receiver holds the output register and
//   the readout waits; the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module reservoir_sampler #(
    parameter int CAPACITY     = 64,
    parameter int RECORD_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rs_in_if.sink         i_in,
    rs_out_if.source      o_out,
    input  logic          i_cfg_we,
    input  rs_pkg::t_size i_cfg_data
);
    import rs_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    rs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    rs_back #(
        .CAPACITY     (CAPACITY),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule
